@@ rtl/core/epd_pkg.sv @@
// ----------------------------------------------------------------------------
// Echo presence detector package
// Shared widths, codes, reset values and types for the detector core.
// ----------------------------------------------------------------------------
package epd_pkg;

	localparam int LIMIT_W    = 24;
	localparam int SAMPLES_W  = 8;
	localparam int PRES_W     = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = LIMIT_W;

	localparam int WIDTH_BITS_DEF = 24;
	localparam int RUN_BITS_DEF   = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_NEAR_LIMIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LEAVE      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ARRIVE     = 2'd2;

	localparam logic [LIMIT_W-1:0]   NEAR_LIMIT_RST = 24'd67060;
	localparam logic [SAMPLES_W-1:0] LEAVE_RST      = 8'd20;
	localparam logic [SAMPLES_W-1:0] ARRIVE_RST     = 8'd5;

	localparam logic [PRES_W-1:0] PRES_INIT     = 3'd0;
	localparam logic [PRES_W-1:0] PRES_HERE     = 3'd1;
	localparam logic [PRES_W-1:0] PRES_AWAY     = 3'd2;
	localparam logic [PRES_W-1:0] PRES_LEAVING  = 3'd3;
	localparam logic [PRES_W-1:0] PRES_ARRIVING = 3'd4;

	typedef struct packed {
		logic [LIMIT_W-1:0]   near_limit;
		logic [SAMPLES_W-1:0] leave_samples;
		logic [SAMPLES_W-1:0] arrive_samples;
	} cfg_t;

	typedef struct packed {
		logic done;
		logic far;
	} meas_t;

endpackage

@@ rtl/core/epd_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// Echo presence detector configuration registers
// Holds the near limit and the two sample counts, written by index.
// ----------------------------------------------------------------------------
module epd_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [epd_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [epd_pkg::CFG_DATA_W-1:0] wr_data,
	output epd_pkg::cfg_t                 cfg
);
	import epd_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.near_limit     <= NEAR_LIMIT_RST;
			cfg_q.leave_samples  <= LEAVE_RST;
			cfg_q.arrive_samples <= ARRIVE_RST;
		end else if (wr_en) begin
			case (wr_index)
				CFG_NEAR_LIMIT: begin
					cfg_q.near_limit <= wr_data[LIMIT_W-1:0];
				end
				CFG_LEAVE: begin
					cfg_q.leave_samples <= wr_data[SAMPLES_W-1:0];
				end
				CFG_ARRIVE: begin
					cfg_q.arrive_samples <= wr_data[SAMPLES_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/core/epd_width_meter.sv @@
// ----------------------------------------------------------------------------
// Echo presence detector width meter
// Counts echo-high ticks with saturation and classifies each pulse on its
// falling edge as near or far against the configured limit.
// ----------------------------------------------------------------------------
module epd_width_meter #(
	parameter int WIDTH_BITS = epd_pkg::WIDTH_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           step,
	input  logic                           level,
	input  logic [epd_pkg::LIMIT_W-1:0]    near_limit,
	output epd_pkg::meas_t                 meas
);
	import epd_pkg::*;

	localparam int CMP_W = (WIDTH_BITS > LIMIT_W) ? WIDTH_BITS : LIMIT_W;
	localparam logic [WIDTH_BITS-1:0] WIDTH_MAX = {WIDTH_BITS{1'b1}};

	logic                  echo_prev_q;
	logic [WIDTH_BITS-1:0] width_count_q;
	logic [CMP_W-1:0]      count_ext;
	logic [CMP_W-1:0]      limit_ext;
	logic                  fall;

	assign count_ext = CMP_W'(width_count_q);
	assign limit_ext = CMP_W'(near_limit);
	assign fall      = !level && echo_prev_q;

	assign meas.done = fall;
	assign meas.far  = fall && (count_ext >= limit_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			echo_prev_q   <= 1'b0;
			width_count_q <= '0;
		end else if (step) begin
			echo_prev_q <= level;
			if (level) begin
				if (width_count_q != WIDTH_MAX) begin
					width_count_q <= width_count_q + WIDTH_BITS'(1);
				end
			end else if (echo_prev_q) begin
				width_count_q <= '0;
			end
		end
	end

endmodule

@@ rtl/core/epd_presence_fsm.sv @@
// ----------------------------------------------------------------------------
// Echo presence detector presence machine
// Five-state presence tracker qualified by runs of far and near measurements.
// ----------------------------------------------------------------------------
module epd_presence_fsm #(
	parameter int RUN_BITS = epd_pkg::RUN_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  epd_pkg::meas_t               meas,
	input  epd_pkg::cfg_t                cfg,
	output logic [epd_pkg::PRES_W-1:0]   presence_next,
	output logic                         toggle
);
	import epd_pkg::*;

	localparam int RCMP_W = (RUN_BITS > SAMPLES_W) ? RUN_BITS : SAMPLES_W;
	localparam logic [RUN_BITS-1:0] RUN_MAX = {RUN_BITS{1'b1}};

	typedef enum logic [PRES_W-1:0] {
		ST_INIT     = PRES_INIT,
		ST_HERE     = PRES_HERE,
		ST_AWAY     = PRES_AWAY,
		ST_LEAVING  = PRES_LEAVING,
		ST_ARRIVING = PRES_ARRIVING
	} state_t;

	state_t              state_q;
	state_t              state_d;
	logic [RUN_BITS-1:0] far_run_q;
	logic [RUN_BITS-1:0] near_run_q;
	logic [RUN_BITS-1:0] far_run_d;
	logic [RUN_BITS-1:0] near_run_d;
	logic [RUN_BITS-1:0] far_inc;
	logic [RUN_BITS-1:0] near_inc;
	logic                far_hit;
	logic                near_hit;
	logic                toggle_d;

	assign far_inc  = (far_run_q != RUN_MAX) ? far_run_q + RUN_BITS'(1) : far_run_q;
	assign near_inc = (near_run_q != RUN_MAX) ? near_run_q + RUN_BITS'(1) : near_run_q;
	assign far_hit  = RCMP_W'(far_inc) >= RCMP_W'(cfg.leave_samples);
	assign near_hit = RCMP_W'(near_inc) >= RCMP_W'(cfg.arrive_samples);

	always_comb begin
		state_d    = state_q;
		far_run_d  = far_run_q;
		near_run_d = near_run_q;
		toggle_d   = 1'b0;
		if (meas.done) begin
			case (state_q)
				ST_HERE: begin
					if (meas.far) begin
						state_d = ST_LEAVING;
					end
				end
				ST_AWAY: begin
					if (!meas.far) begin
						state_d = ST_ARRIVING;
					end
				end
				ST_LEAVING: begin
					if (meas.far) begin
						if (far_hit) begin
							state_d   = ST_AWAY;
							far_run_d = '0;
							toggle_d  = 1'b1;
						end else begin
							far_run_d = far_inc;
						end
					end else begin
						state_d   = ST_HERE;
						far_run_d = '0;
					end
				end
				ST_ARRIVING: begin
					if (meas.far) begin
						state_d    = ST_AWAY;
						near_run_d = '0;
					end else if (near_hit) begin
						state_d    = ST_HERE;
						near_run_d = '0;
						toggle_d   = 1'b1;
					end else begin
						near_run_d = near_inc;
					end
				end
				default: begin
					state_d = ST_HERE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_INIT;
			far_run_q  <= '0;
			near_run_q <= '0;
		end else if (step) begin
			state_q    <= state_d;
			far_run_q  <= far_run_d;
			near_run_q <= near_run_d;
		end
	end

	assign presence_next = state_d;
	assign toggle        = toggle_d;

endmodule

@@ rtl/core/echo_presence_detector_core.sv @@
// ----------------------------------------------------------------------------
// Echo presence detector core
// Measures ultrasonic echo pulse widths one tick per transaction and tracks
// presence of a target in front of the sensor.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake                 Payload
//  in       input      in_valid / in_stall       echo_level
//  out      output     out_valid / out_stall     presence_state, measure_done,
//                                                measured_far, toggle_pulse
//  cfg      input      cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One transaction is taken per cycle while in_stall is low.
// The path runs from the input register through the width compare and the
// presence machine into the result register.
// Reset clears the width counter, the run counters and the presence state,
// and loads the register defaults.
// A stalled output holds the pipeline; the input register still takes a
// transaction while it is empty.
module echo_presence_detector_core #(
	parameter int WIDTH_BITS = epd_pkg::WIDTH_BITS_DEF,
	parameter int RUN_BITS   = epd_pkg::RUN_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           echo_level,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [epd_pkg::PRES_W-1:0]     presence_state,
	output logic                           measure_done,
	output logic                           measured_far,
	output logic                           toggle_pulse,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [epd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [epd_pkg::CFG_DATA_W-1:0] cfg_data
);
	import epd_pkg::*;

	cfg_t              cfg;
	meas_t             meas;
	logic              valid_s1;
	logic              echo_s1;
	logic              advance;
	logic              step;
	logic [PRES_W-1:0] presence_next;
	logic              toggle;
	logic              out_valid_q;
	logic [PRES_W-1:0] presence_q;
	logic              done_q;
	logic              far_q;
	logic              toggle_q;

	assign advance   = !out_valid_q || !out_stall;
	assign step      = valid_s1 && advance;
	assign in_stall  = valid_s1 && !advance;
	assign cfg_ready = 1'b1;

	epd_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			echo_s1 <= echo_level;
		end
	end

	epd_width_meter #(
		.WIDTH_BITS (WIDTH_BITS)
	) u_meter (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.level      (echo_s1),
		.near_limit (cfg.near_limit),
		.meas       (meas)
	);

	epd_presence_fsm #(
		.RUN_BITS (RUN_BITS)
	) u_fsm (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.meas          (meas),
		.cfg           (cfg),
		.presence_next (presence_next),
		.toggle        (toggle)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			presence_q <= presence_next;
			done_q     <= meas.done;
			far_q      <= meas.far;
			toggle_q   <= toggle;
		end
	end

	assign out_valid      = out_valid_q;
	assign presence_state = presence_q;
	assign measure_done   = done_q;
	assign measured_far   = far_q;
	assign toggle_pulse   = toggle_q;

endmodule

@@ rtl/core/epd_checker.sv @@
// ----------------------------------------------------------------------------
// Echo presence detector checker
// Port-level properties of the detector core, attached by a bind statement.
// ----------------------------------------------------------------------------
module epd_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [epd_pkg::PRES_W-1:0] presence_state,
	input logic                       measure_done,
	input logic                       measured_far,
	input logic                       toggle_pulse
);
	import epd_pkg::*;

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(presence_state)
			&& $stable(measure_done) && $stable(measured_far) && $stable(toggle_pulse))
		else $error("Result changed while the output transaction was stalled.");

	a_far_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && measured_far |-> measure_done)
		else $error("Far flag raised without a completed measurement.");

	a_toggle_confirms: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && toggle_pulse |-> measure_done
			&& (presence_state == PRES_HERE || presence_state == PRES_AWAY))
		else $error("Toggle pulse without a confirmed here or away state.");

	a_leave_init: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && measure_done |-> presence_state != PRES_INIT)
		else $error("Presence stayed in init after a measurement.");

endmodule

bind echo_presence_detector_core epd_checker u_epd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.presence_state (presence_state),
	.measure_done   (measure_done),
	.measured_far   (measured_far),
	.toggle_pulse   (toggle_pulse)
);

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// Echo presence detector core testbench
// Feeds echo level ticks through the input channel in random bursts. The
// receiver stalls the output on a changing pattern. A model of the width
// counter and the presence machine, kept in the monitor, predicts the status
// for every accepted tick. Each result is checked field by field against the
// oldest prediction. The run steps through several register settings,
// including the extreme limits and sample counts.
// ----------------------------------------------------------------------------
module tb;
	import epd_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
	localparam int LIMIT_CYCLES = 400000;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int MAX_PRINTED = 200;

	typedef struct packed {
		logic [PRES_W-1:0] state;
		logic              done;
		logic              far;
		logic              toggle;
	} det_status_t;

	typedef enum int {
		RX_FREE,
		RX_LIGHT,
		RX_HEAVY,
		RX_PERIODIC
	} rx_mode_e;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  echo_level = 1'b0;
	logic                  out_valid;
	logic                  out_stall = 1'b1;
	logic [PRES_W-1:0]     presence_state;
	logic                  measure_done;
	logic                  measured_far;
	logic                  toggle_pulse;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	bit                    echo_feed_q[$];
	det_status_t           pending_status_q[$];
	int                    err_count = 0;
	int                    queued_items = 0;
	int                    cycle_count = 0;
	logic                  in_fire = 1'b0;

	// Predicted detector state and registers.
	logic [LIMIT_W-1:0]        near_limit_q = NEAR_LIMIT_RST;
	logic [SAMPLES_W-1:0]      leave_q = LEAVE_RST;
	logic [SAMPLES_W-1:0]      arrive_q = ARRIVE_RST;
	logic                      echo_prev_q = 1'b0;
	logic [WIDTH_BITS_DEF-1:0] width_cnt = '0;
	logic [PRES_W-1:0]         pres_q = PRES_INIT;
	logic [RUN_BITS_DEF-1:0]   far_run_q = '0;
	logic [RUN_BITS_DEF-1:0]   near_run_q = '0;

	int                    gap_left = 0;
	int                    burst_left = 1;
	rx_mode_e              rx_mode = RX_FREE;
	int                    rx_mode_left = 0;
	int                    hold_left = 0;
	bit                    long_hold_arm = 1'b0;
	bit                    long_hold_done = 1'b0;

	echo_presence_detector_core i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.echo_level     (echo_level),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.presence_state (presence_state),
		.measure_done   (measure_done),
		.measured_far   (measured_far),
		.toggle_pulse   (toggle_pulse),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic flag_error(input string msg);
		if (err_count < MAX_PRINTED) begin
			$display("ERROR at %0t: %s", $time, msg);
		end
		err_count++;
	endtask

	function automatic logic [RUN_BITS_DEF-1:0] bump_run(input logic [RUN_BITS_DEF-1:0] r);
		return (r == '1) ? r : r + 1'b1;
	endfunction

	task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		case (idx)
			CFG_NEAR_LIMIT: begin
				near_limit_q = val[LIMIT_W-1:0];
			end
			CFG_LEAVE: begin
				leave_q = val[SAMPLES_W-1:0];
			end
			CFG_ARRIVE: begin
				arrive_q = val[SAMPLES_W-1:0];
			end
			default: begin
			end
		endcase
	endtask

	task automatic detector_tick(input logic lvl);
		det_status_t s;
		logic        far_m;
		s = '0;
		if (lvl) begin
			if (width_cnt != '1) begin
				width_cnt = width_cnt + 1'b1;
			end
		end else if (echo_prev_q) begin
			far_m = (width_cnt >= near_limit_q);
			s.done = 1'b1;
			s.far = far_m;
			case (pres_q)
				PRES_HERE: begin
					if (far_m) begin
						pres_q = PRES_LEAVING;
					end
				end
				PRES_AWAY: begin
					if (!far_m) begin
						pres_q = PRES_ARRIVING;
					end
				end
				PRES_LEAVING: begin
					if (far_m) begin
						far_run_q = bump_run(far_run_q);
						if (far_run_q >= leave_q) begin
							pres_q = PRES_AWAY;
							far_run_q = '0;
							s.toggle = 1'b1;
						end
					end else begin
						pres_q = PRES_HERE;
						far_run_q = '0;
					end
				end
				PRES_ARRIVING: begin
					if (far_m) begin
						pres_q = PRES_AWAY;
						near_run_q = '0;
					end else begin
						near_run_q = bump_run(near_run_q);
						if (near_run_q >= arrive_q) begin
							pres_q = PRES_HERE;
							near_run_q = '0;
							s.toggle = 1'b1;
						end
					end
				end
				default: begin
					pres_q = PRES_HERE;
				end
			endcase
			width_cnt = '0;
		end
		echo_prev_q = lvl;
		s.state = pres_q;
		pending_status_q.push_back(s);
	endtask

	task automatic check_status();
		det_status_t want;
		if (pending_status_q.size() == 0) begin
			flag_error($sformatf("result with no transaction pending, state %0d", presence_state));
			return;
		end
		want = pending_status_q.pop_front();
		if (presence_state !== want.state) begin
			flag_error($sformatf("presence_state %0d, expected %0d", presence_state, want.state));
		end
		if (measure_done !== want.done) begin
			flag_error($sformatf("measure_done %0b, expected %0b", measure_done, want.done));
		end
		if (measured_far !== want.far) begin
			flag_error($sformatf("measured_far %0b, expected %0b", measured_far, want.far));
		end
		if (toggle_pulse !== want.toggle) begin
			flag_error($sformatf("toggle_pulse %0b, expected %0b", toggle_pulse, want.toggle));
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				apply_reg(cfg_index, cfg_data);
			end
			if (in_valid && !in_stall) begin
				detector_tick(echo_level);
			end
			if (out_valid && !out_stall) begin
				check_status();
			end
		end
		in_fire <= arst_n && in_valid && !in_stall;
	end

	always @(negedge clk) begin
		logic nxt_valid;
		logic nxt_level;
		nxt_valid = in_valid;
		nxt_level = echo_level;
		if (in_valid && in_fire) begin
			nxt_valid = 1'b0;
		end
		if (!nxt_valid && arst_n) begin
			if (gap_left > 0) begin
				gap_left--;
			end else if (echo_feed_q.size() > 0) begin
				nxt_level = echo_feed_q.pop_front();
				nxt_valid = 1'b1;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
		end
		in_valid <= nxt_valid;
		echo_level <= nxt_level;
	end

	always @(negedge clk) begin
		logic stall;
		stall = 1'b0;
		if (long_hold_arm && !long_hold_done) begin
			hold_left = LONG_HOLD_CYCLES;
			long_hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			stall = 1'b1;
		end else begin
			if (rx_mode_left <= 0) begin
				rx_mode = rx_mode_e'($urandom_range(0, 3));
				rx_mode_left = $urandom_range(8, 80);
			end
			rx_mode_left--;
			case (rx_mode)
				RX_FREE: begin
					stall = 1'b0;
				end
				RX_LIGHT: begin
					stall = ($urandom_range(0, 3) == 0);
				end
				RX_HEAVY: begin
					stall = ($urandom_range(0, 3) != 0);
				end
				default: begin
					stall = rx_mode_left[2];
				end
			endcase
		end
		out_stall <= stall;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("** echo_presence_detector_core: FAILED **");
			$finish;
		end
	end

	task automatic push_level(input bit lvl);
		echo_feed_q.push_back(lvl);
		queued_items++;
	endtask

	task automatic push_pulse(input int hi, input int lo);
		repeat (hi) push_level(1'b1);
		repeat (lo) push_level(1'b0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_regs(input logic [CFG_DATA_W-1:0] limit, input int leave_n,
			input int arrive_n);
		write_reg(CFG_NEAR_LIMIT, limit);
		write_reg(CFG_LEAVE, CFG_DATA_W'(leave_n));
		write_reg(CFG_ARRIVE, CFG_DATA_W'(arrive_n));
	endtask

	// Waits until every queued tick has been taken and every result has come,
	// then lets the pipeline settle before the registers change.
	task automatic settle();
		while (echo_feed_q.size() != 0 || in_valid || pending_status_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(negedge clk);
	endtask

	// Runs of near or far pulses sized around the sample counts, mixed with
	// random level noise.
	task automatic queue_mixed(input int n_items, input int limit, input int leave_n,
			input int arrive_n);
		int  start;
		int  run_len;
		int  thr;
		int  hi;
		int  base;
		bit  want_far;
		bit  can_near;
		bit  can_far;
		start = queued_items;
		can_near = (limit > 1);
		can_far = (limit <= 64);
		while (queued_items - start < n_items) begin
			if ($urandom_range(0, 9) < 2) begin
				repeat ($urandom_range(1, 12)) push_level(bit'($urandom_range(0, 1)));
			end else begin
				want_far = can_far && (!can_near || $urandom_range(0, 1));
				thr = want_far ? leave_n : arrive_n;
				if (thr > 28) begin
					thr = 28;
				end
				run_len = $urandom_range(1, thr + 2);
				repeat (run_len) begin
					if (want_far) begin
						base = (limit < 1) ? 1 : limit;
						hi = $urandom_range(base, base + 3);
					end else begin
						hi = $urandom_range(1, (limit - 1 > 12) ? 12 : limit - 1);
					end
					push_pulse(hi, $urandom_range(1, 3));
				end
			end
		end
	endtask

	initial begin
		int lim;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: the first measurement leaves init, short pulses are near.
		push_level(1'b0);
		push_level(1'b0);
		push_pulse(1, 1);
		push_pulse(3, 2);
		settle();

		// Zero limit and zero sample counts, then the largest limit.
		set_regs('0, 0, 0);
		write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
		push_pulse(1, 1);
		push_pulse(2, 1);
		push_pulse(1, 2);
		settle();
		set_regs('1, 0, 0);
		push_pulse(1, 1);
		push_pulse(2, 1);
		push_pulse(4, 1);
		push_level(1'b1);
		settle();

		set_regs(24'd4, 3, 2);
		queue_mixed(140, 4, 3, 2);
		settle();

		set_regs(24'd6, 1, 1);
		queue_mixed(110, 6, 1, 1);
		settle();

		lim = $urandom_range(2, 8);
		set_regs(CFG_DATA_W'(lim), $urandom_range(1, 6), $urandom_range(1, 6));
		queue_mixed(140, lim, int'(leave_q), int'(arrive_q));
		settle();

		set_regs('1, 2, 3);
		queue_mixed(50, 24'hFFFFFF, 2, 3);
		settle();

		set_regs(24'd1, 5, 4);
		queue_mixed(50, 1, 5, 4);
		settle();

		// Two near pulses bring the machine back to here.
		set_regs(24'd2, 255, 1);
		push_pulse(1, 1);
		push_pulse(1, 1);
		settle();

		// Largest sample counts: with a limit of one tick every pulse is far,
		// and the far run climbs to the top of the run counter. The receiver
		// holds off for a long stretch here.
		set_regs(24'd1, 255, 255);
		long_hold_arm = 1'b1;
		repeat (257) push_pulse(1, 1);
		settle();

		set_regs(NEAR_LIMIT_RST, LEAVE_RST, ARRIVE_RST);
		write_reg(CFG_SPARE, '1);
		push_pulse(5, 2);
		settle();
		set_regs(24'd3, 2, 2);
		queue_mixed(50, 3, 2, 2);
		settle();

		repeat (8) @(negedge clk);
		if (pending_status_q.size() != 0) begin
			flag_error($sformatf("%0d results never arrived", pending_status_q.size()));
		end
		if (err_count == 0) begin
			$display("** echo_presence_detector_core: PASSED **");
		end else begin
			$display("** echo_presence_detector_core: FAILED **");
		end
		$finish;
	end

endmodule
